// File: rtl/pwn_pkg.sv
// Shared constants and word types of the polygon winding number block.
package pwn_pkg;

  localparam int COORD_BITS  = 16;
  localparam int REL_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * REL_BITS;
  localparam int COUNT_BITS  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QLVL_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_vertex;
  } pwn_in_t;

  typedef struct packed {
    logic signed [COUNT_BITS-1:0] winding_number;
    logic                         inside_res;
  } pwn_out_t;

  typedef struct packed {
    logic signed [REL_BITS-1:0] x;
    logic signed [REL_BITS-1:0] y;
  } rel_pt_t;

  typedef struct packed {
    rel_pt_t prev;
    rel_pt_t cur;
    rel_pt_t first;
    logic    has_prev;
    logic    first_v;
    logic    last;
  } edge_word_t;

  typedef struct packed {
    logic [QLVL_BITS-1:0] level;
    logic                 full;
  } queue_status_t;

  typedef struct packed {
    logic s1_valid;
    logic commit;
  } back_status_t;

endpackage

// File: rtl/polygon_winding_number.sv
// Top level of the polygon winding number block.
//
// Usage: vertices of one closed polygon arrive as words on the input channel
// (in_valid_i / in_ready_o), one vertex per word. The first word of a polygon
// also carries the query point; later point fields are ignored. The word with
// last_vertex set closes the polygon, and exactly one result word then leaves
// on the output channel (out_valid_o / out_ready_i) with the saturated winding
// number and an inside flag. Other vertices give no result.
// Throughput is one vertex per cycle unless a result is held. The front end
// takes a vertex each cycle the two-entry edge queue has room; the back end
// pops one edge word a cycle unless a last word waits on a held result, and
// its single count register closes the loop over consecutive edges.
// While the receiver stalls, the result is held and vertices of the following
// polygon keep flowing until its own last word reaches the count stage.
// Reset clears the queue, the count and the result valid flag; the next vertex
// is taken as the first vertex of a new polygon.
module polygon_winding_number (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pwn_pkg::pwn_in_t  in_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output pwn_pkg::pwn_out_t out_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);
  import pwn_pkg::*;

  edge_word_t    push_word, pop_word;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  queue_status_t q_st;
  back_status_t  bk_st;

  pwn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .word_o       (push_word),
    .word_valid_o (push_valid),
    .word_ready_i (push_ready)
  );

  pwn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_word),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_o        (pop_word),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .status_o     (q_st)
  );

  pwn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (pop_word),
    .word_valid_i (pop_valid),
    .word_ready_o (pop_ready),
    .out_o        (out_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (bk_st)
  );

  a_inside_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.inside_res == (out_o.winding_number != '0)))
    else $error("inside flag disagrees with winding number");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bk_st.s1_valid |=> !$rose(out_valid_o))
    else $error("result appeared without a word in the count stage");

  a_commit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_st.commit |-> bk_st.s1_valid)
    else $error("count stage committed without a word");

  a_queue_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_st.level <= QLVL_BITS'(QUEUE_DEPTH))
    else $error("edge queue overfilled");

  a_queue_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_st.full |-> !in_ready_o)
    else $error("vertex accepted while the edge queue was full");

endmodule

// File: rtl/pwn_front.sv
// Front end: makes each vertex relative to the query point and forms its edge word.
module pwn_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pwn_pkg::pwn_in_t    in_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output pwn_pkg::edge_word_t word_o,
  output logic                word_valid_o,
  input  logic                word_ready_i
);
  import pwn_pkg::*;

  logic                         in_polygon_q;
  logic signed [COORD_BITS-1:0] qp_x_q, qp_y_q;
  rel_pt_t                      first_q, prev_q;
  logic signed [COORD_BITS-1:0] base_x, base_y;
  rel_pt_t                      cur;
  logic                         push;

  always_comb begin
    base_x = in_polygon_q ? qp_x_q : in_i.point_x;
    base_y = in_polygon_q ? qp_y_q : in_i.point_y;
    cur.x  = REL_BITS'(in_i.vertex_x) - REL_BITS'(base_x);
    cur.y  = REL_BITS'(in_i.vertex_y) - REL_BITS'(base_y);
    word_o.prev     = in_polygon_q ? prev_q : cur;
    word_o.cur      = cur;
    word_o.first    = in_polygon_q ? first_q : cur;
    word_o.has_prev = in_polygon_q;
    word_o.first_v  = ~in_polygon_q;
    word_o.last     = in_i.last_vertex;
  end

  assign word_valid_o = in_valid_i;
  assign in_ready_o   = word_ready_i;
  assign push         = in_valid_i & word_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_polygon_q <= 1'b0;
      qp_x_q       <= '0;
      qp_y_q       <= '0;
      first_q      <= '0;
      prev_q       <= '0;
    end else if (push) begin
      if (!in_polygon_q) begin
        qp_x_q  <= in_i.point_x;
        qp_y_q  <= in_i.point_y;
        first_q <= cur;
      end
      prev_q       <= cur;
      in_polygon_q <= ~in_i.last_vertex;
    end
  end

endmodule

// File: rtl/pwn_queue.sv
// Short queue of edge words between the front end and the back end.
module pwn_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pwn_pkg::edge_word_t    push_i,
  input  logic                   push_valid_i,
  output logic                   push_ready_o,
  output pwn_pkg::edge_word_t    pop_o,
  output logic                   pop_valid_o,
  input  logic                   pop_ready_i,
  output pwn_pkg::queue_status_t status_o
);
  import pwn_pkg::*;

  edge_word_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QLVL_BITS-1:0] level_q;
  logic                 full, push, pop;

  assign full         = (level_q == QLVL_BITS'(QUEUE_DEPTH));
  assign push_ready_o = ~full;
  assign pop_valid_o  = (level_q != '0);
  assign pop_o        = mem_q[rd_ptr_q];
  assign push         = push_valid_i & ~full;
  assign pop          = pop_valid_o & pop_ready_i;
  assign status_o     = '{level: level_q, full: full};

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   level_q <= level_q + 1'b1;
        2'b01:   level_q <= level_q - 1'b1;
        default: level_q <= level_q;
      endcase
    end
  end

endmodule

// File: rtl/pwn_back.sv
// Back end: edge crossing tests, saturating winding count and the result register.
module pwn_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pwn_pkg::edge_word_t   word_i,
  input  logic                  word_valid_i,
  output logic                  word_ready_o,
  output pwn_pkg::pwn_out_t     out_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pwn_pkg::back_status_t status_o
);
  import pwn_pkg::*;

  localparam logic signed [COUNT_BITS-1:0] CountMax = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CountMin = {1'b1, {(COUNT_BITS-1){1'b0}}};

  typedef struct packed {
    logic                        act;
    logic                        sure;
    logic                        down;
    logic signed [PROD_BITS-1:0] lhs;
    logic signed [PROD_BITS-1:0] rhs;
  } edge_eval_t;

  typedef struct packed {
    logic       first_v;
    logic       last;
    edge_eval_t e1;
    edge_eval_t e2;
  } stage_t;

  function automatic edge_eval_t eval_edge(rel_pt_t a, rel_pt_t b, logic en);
    edge_eval_t r;
    logic       a_pos, b_pos, up;
    a_pos  = ~a.y[REL_BITS-1] & (a.y != '0);
    b_pos  = ~b.y[REL_BITS-1] & (b.y != '0);
    r.down = a_pos & ~b_pos;
    up     = ~a_pos & b_pos;
    r.act  = en & ~(a.x[REL_BITS-1] & b.x[REL_BITS-1]) & (r.down | up);
    r.sure = ~a.x[REL_BITS-1] & ~b.x[REL_BITS-1];
    r.lhs  = PROD_BITS'(a.x) * PROD_BITS'(b.y);
    r.rhs  = PROD_BITS'(a.y) * PROD_BITS'(b.x);
    return r;
  endfunction

  function automatic logic signed [COUNT_BITS-1:0] count_step(
    logic signed [COUNT_BITS-1:0] c, edge_eval_t e);
    logic inc, dec;
    inc = e.act & e.down & (e.sure | (e.lhs <= e.rhs));
    dec = e.act & ~e.down & (e.sure | (e.lhs > e.rhs));
    if (inc && c != CountMax) begin
      return c + 1'b1;
    end else if (dec && c != CountMin) begin
      return c - 1'b1;
    end
    return c;
  endfunction

  stage_t                       s1_q;
  logic                         s1_valid_q;
  logic signed [COUNT_BITS-1:0] count_q;
  logic signed [COUNT_BITS-1:0] c1, c2;
  pwn_out_t                     out_q;
  logic                         out_valid_q;
  logic                         out_free, commit, load;

  assign out_free     = ~out_valid_q | out_ready_i;
  assign commit       = s1_valid_q & (~s1_q.last | out_free);
  assign word_ready_o = ~s1_valid_q | commit;
  assign load         = word_valid_i & word_ready_o;

  always_comb begin
    c1 = count_step(s1_q.first_v ? '0 : count_q, s1_q.e1);
    c2 = count_step(c1, s1_q.e2);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_q.first_v <= word_i.first_v;
      s1_q.last    <= word_i.last;
      s1_q.e1      <= eval_edge(word_i.prev, word_i.cur, word_i.has_prev);
      s1_q.e2      <= eval_edge(word_i.cur, word_i.first, word_i.last);
    end
    if (commit && s1_q.last) begin
      out_q.winding_number <= c2;
      out_q.inside_res     <= (c2 != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_q <= 1'b1;
      end else if (commit) begin
        s1_valid_q <= 1'b0;
      end
      if (commit) begin
        count_q <= c2;
      end
      if (commit && s1_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = '{s1_valid: s1_valid_q, commit: commit};

endmodule

// File: tb/polygon_winding_number_tb.sv
// Self-checking testbench of the polygon winding number block, with a predicted winding count per polygon.
`timescale 1ns / 1ps

module polygon_winding_number_tb;
  import pwn_pkg::*;

  localparam int COUNT_TOP    = 2 ** (COUNT_BITS - 1) - 1;
  localparam int COUNT_BOTTOM = -(2 ** (COUNT_BITS - 1));
  localparam int RANDOM_WORDS = 1700;
  localparam int LONG_HOLD    = 300;

  typedef struct {
    logic signed [REL_BITS-1:0] x;
    logic signed [REL_BITS-1:0] y;
  } rel_vec_t;

  typedef struct {
    pwn_in_t word;
    bit      calm;
    bit      hold_for_drain;
  } vertex_job_t;

  typedef enum {SHAPE_WILD, SHAPE_NEAR, SHAPE_CORNER, SHAPE_TIGHT} shape_e;

  logic     clk;
  logic     rst_n = 1'b0;
  pwn_in_t  vtx_word = '0;
  logic     vtx_valid = 1'b0;
  logic     vtx_ready;
  pwn_out_t res_word;
  logic     res_valid;
  logic     res_ready = 1'b0;

  vertex_job_t pending_q[$];
  pwn_out_t    result_q[$];

  logic signed [COORD_BITS-1:0] anchor_x = '0;
  logic signed [COORD_BITS-1:0] anchor_y = '0;
  rel_vec_t                     first_rel;
  rel_vec_t                     prev_rel;
  logic signed [COUNT_BITS-1:0] wind_cnt = '0;
  bit                           mid_poly = 1'b0;

  int gap_left       = 0;
  int ready_off      = 0;
  bit long_hold_done = 1'b0;
  bit quiet_recv     = 1'b0;
  int words_accepted = 0;
  int total_words    = 0;
  int results_seen   = 0;
  int mismatch_cnt   = 0;

  polygon_winding_number i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (vtx_word),
    .in_valid_i  (vtx_valid),
    .in_ready_o  (vtx_ready),
    .out_o       (res_word),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int crossing_delta(input rel_vec_t a, input rel_vec_t b);
    bit                          down;
    bit                          up;
    logic signed [PROD_BITS-1:0] lhs;
    logic signed [PROD_BITS-1:0] rhs;
    if (a.x < 0 && b.x < 0) return 0;
    down = (a.y > 0) && (b.y <= 0);
    up   = (a.y <= 0) && (b.y > 0);
    if (!down && !up) return 0;
    if (a.x >= 0 && b.x >= 0) return down ? 1 : -1;
    lhs = a.x * b.y;
    rhs = a.y * b.x;
    if (down) return (lhs <= rhs) ? 1 : 0;
    return (lhs > rhs) ? -1 : 0;
  endfunction

  function automatic logic signed [COUNT_BITS-1:0] sat_add(
    input logic signed [COUNT_BITS-1:0] c, input int d);
    int n;
    n = c + d;
    if (n > COUNT_TOP) n = COUNT_TOP;
    if (n < COUNT_BOTTOM) n = COUNT_BOTTOM;
    return n[COUNT_BITS-1:0];
  endfunction

  task automatic track_vertex(input pwn_in_t w);
    rel_vec_t here;
    pwn_out_t res;
    if (!mid_poly) begin
      anchor_x  = w.point_x;
      anchor_y  = w.point_y;
      here.x    = $signed(w.vertex_x) - anchor_x;
      here.y    = $signed(w.vertex_y) - anchor_y;
      first_rel = here;
      prev_rel  = here;
      wind_cnt  = '0;
      mid_poly  = 1'b1;
    end else begin
      here.x   = $signed(w.vertex_x) - anchor_x;
      here.y   = $signed(w.vertex_y) - anchor_y;
      wind_cnt = sat_add(wind_cnt, crossing_delta(prev_rel, here));
      prev_rel = here;
    end
    if (w.last_vertex) begin
      wind_cnt = sat_add(wind_cnt, crossing_delta(prev_rel, first_rel));
      mid_poly = 1'b0;
      res.winding_number = wind_cnt;
      res.inside_res     = (wind_cnt != 0);
      result_q.push_back(res);
    end
  endtask

  function automatic int any_coord();
    return int'($urandom_range(0, 2 ** COORD_BITS - 1));
  endfunction

  function automatic int corner_coord();
    case ($urandom_range(0, 6))
      0: return COUNT_BOTTOM;
      1: return COUNT_BOTTOM + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return COUNT_TOP - 1;
      default: return COUNT_TOP;
    endcase
  endfunction

  task automatic queue_vertex(input int vx, input int vy, input int px, input int py,
                              input bit last, input bit calm, input bit drain);
    vertex_job_t job;
    job.word.vertex_x    = vx[COORD_BITS-1:0];
    job.word.vertex_y    = vy[COORD_BITS-1:0];
    job.word.point_x     = px[COORD_BITS-1:0];
    job.word.point_y     = py[COORD_BITS-1:0];
    job.word.last_vertex = last;
    job.calm             = calm;
    job.hold_for_drain   = drain;
    pending_q.push_back(job);
  endtask

  always @(posedge clk or negedge rst_n) begin : vertex_driver
    vertex_job_t job;
    bit          offer;
    if (!rst_n) begin
      vtx_valid  <= 1'b0;
      vtx_word   <= '0;
      gap_left   <= 0;
      quiet_recv <= 1'b0;
    end else begin
      offer = 1'b0;
      if (vtx_valid && vtx_ready) begin
        track_vertex(vtx_word);
        words_accepted++;
      end
      if (vtx_valid && !vtx_ready) begin
        offer = 1'b1;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].hold_for_drain && result_q.size() != 0)) begin
        if (!pending_q[0].calm && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 9);
        end else begin
          job = pending_q.pop_front();
          vtx_word   <= job.word;
          quiet_recv <= job.calm;
          offer = 1'b1;
        end
      end
      vtx_valid <= offer;
    end
  end

  always @(posedge clk or negedge rst_n) begin : result_monitor
    pwn_out_t want;
    bit       take;
    if (!rst_n) begin
      res_ready      <= 1'b0;
      ready_off      <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $error("winding_number: expected no word, got %0d", res_word.winding_number);
          mismatch_cnt++;
        end else begin
          want = result_q.pop_front();
          if (res_word.winding_number !== want.winding_number) begin
            $error("winding_number: expected %0d, got %0d",
                   want.winding_number, res_word.winding_number);
            mismatch_cnt++;
          end
          if (res_word.inside_res !== want.inside_res) begin
            $error("inside_res: expected %0b, got %0b", want.inside_res, res_word.inside_res);
            mismatch_cnt++;
          end
        end
      end
      take = 1'b0;
      if (ready_off != 0) begin
        ready_off <= ready_off - 1;
      end else if (!long_hold_done && results_seen >= 60) begin
        long_hold_done <= 1'b1;
        ready_off      <= LONG_HOLD - 1;
      end else if (!quiet_recv && $urandom_range(0, 4) == 0) begin
        ready_off <= $urandom_range(0, 9);
      end else begin
        take = 1'b1;
      end
      res_ready <= take;
    end
  end

  initial begin
    int     k;
    int     n_vtx;
    int     placed;
    int     poly_idx;
    int     px;
    int     py;
    int     vx;
    int     vy;
    bit     calm;
    shape_e shape;

    // Single vertices: one with the coordinates at opposite extremes, one all at zero.
    queue_vertex(COUNT_TOP, COUNT_BOTTOM, COUNT_BOTTOM, COUNT_TOP, 1'b1, 1'b0, 1'b0);
    queue_vertex(0, 0, 0, 0, 1'b1, 1'b0, 1'b0);
    // A small square around the point, anticlockwise and then clockwise.
    for (k = 0; k < 4; k++) begin
      queue_vertex(100 + ((k == 1 || k == 2) ? 10 : -10), -200 + ((k >= 2) ? 10 : -10),
                   (k == 0) ? 100 : any_coord(), (k == 0) ? -200 : any_coord(),
                   k == 3, 1'b0, 1'b0);
    end
    for (k = 3; k >= 0; k--) begin
      queue_vertex(100 + ((k == 1 || k == 2) ? 10 : -10), -200 + ((k >= 2) ? 10 : -10),
                   (k == 3) ? 100 : any_coord(), (k == 3) ? -200 : any_coord(),
                   k == 0, 1'b0, 1'b0);
    end
    // Triangles whose relative coordinates reach the widest values.
    queue_vertex(COUNT_BOTTOM, COUNT_TOP, 0, 0, 1'b0, 1'b0, 1'b0);
    queue_vertex(COUNT_TOP, COUNT_BOTTOM, any_coord(), any_coord(), 1'b0, 1'b0, 1'b0);
    queue_vertex(COUNT_TOP, COUNT_TOP, any_coord(), any_coord(), 1'b1, 1'b0, 1'b0);
    queue_vertex(COUNT_TOP, COUNT_TOP, COUNT_BOTTOM, COUNT_BOTTOM, 1'b0, 1'b0, 1'b0);
    queue_vertex(COUNT_TOP, COUNT_BOTTOM, any_coord(), any_coord(), 1'b0, 1'b0, 1'b0);
    queue_vertex(COUNT_BOTTOM, COUNT_TOP, any_coord(), any_coord(), 1'b1, 1'b0, 1'b0);
    queue_vertex(COUNT_BOTTOM, COUNT_BOTTOM, COUNT_TOP, COUNT_TOP, 1'b0, 1'b0, 1'b0);
    queue_vertex(COUNT_BOTTOM, COUNT_TOP, any_coord(), any_coord(), 1'b0, 1'b0, 1'b0);
    queue_vertex(COUNT_TOP, COUNT_BOTTOM, any_coord(), any_coord(), 1'b1, 1'b0, 1'b0);
    // An edge through the point itself, and an edge lying along the ray.
    queue_vertex(0, 5, 0, 0, 1'b0, 1'b0, 1'b0);
    queue_vertex(0, -5, any_coord(), any_coord(), 1'b0, 1'b0, 1'b0);
    queue_vertex(-3, 0, any_coord(), any_coord(), 1'b1, 1'b0, 1'b0);
    queue_vertex(5, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    queue_vertex(10, 0, any_coord(), any_coord(), 1'b0, 1'b0, 1'b0);
    queue_vertex(10, 3, any_coord(), any_coord(), 1'b1, 1'b0, 1'b0);

    placed   = 0;
    poly_idx = 0;
    while (placed < RANDOM_WORDS) begin
      n_vtx = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      shape = shape_e'($urandom_range(0, 3));
      calm  = (poly_idx % 12 == 5) || (placed > RANDOM_WORDS - 250);
      px    = (shape == SHAPE_CORNER) ? corner_coord() : any_coord();
      py    = (shape == SHAPE_CORNER) ? corner_coord() : any_coord();
      for (k = 0; k < n_vtx; k++) begin
        case (shape)
          SHAPE_WILD: begin
            vx = any_coord();
            vy = any_coord();
          end
          SHAPE_NEAR: begin
            vx = px + int'($urandom_range(0, 40)) - 20;
            vy = py + int'($urandom_range(0, 40)) - 20;
          end
          SHAPE_CORNER: begin
            vx = corner_coord();
            vy = corner_coord();
          end
          default: begin
            vx = px + int'($urandom_range(0, 6)) - 3;
            vy = py + int'($urandom_range(0, 6)) - 3;
          end
        endcase
        queue_vertex(vx, vy, (k == 0) ? px : any_coord(), (k == 0) ? py : any_coord(),
                     k == n_vtx - 1, calm, (k == 0) && (poly_idx == 120 || poly_idx == 260));
        placed++;
      end
      poly_idx++;
    end
    total_words = pending_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (words_accepted < total_words) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("polygon_winding_number_tb: clean");
    end else begin
      $display("polygon_winding_number_tb: errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("polygon_winding_number_tb: errors");
    $finish;
  end

endmodule

// File: polygon_winding_number.f
rtl/pwn_pkg.sv
rtl/pwn_front.sv
rtl/pwn_queue.sv
rtl/pwn_back.sv
rtl/polygon_winding_number.sv
tb/polygon_winding_number_tb.sv
